>>> sv/sliding_median_spike_alert_defines.svh
// assertion macros used by the top-level asserting file
`ifndef SLIDING_MEDIAN_SPIKE_ALERT_DEFINES_SVH
`define SLIDING_MEDIAN_SPIKE_ALERT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, quiet during reset
`define SMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, quiet during reset
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sms_pkg.sv
`timescale 1ns / 1ps

package sms_pkg;

    // window and sample sizing
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_BITS    = $clog2(WINDOW_MAX);
    localparam int FILL_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int LEN_BITS    = 7;
    localparam int DBL_BITS    = SAMPLE_BITS + 1;
    localparam int CNT_BITS    = 32;

    // register port sizing
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    // register map
    localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = REG_IDX_BITS'(0);

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic remove;
        logic insert;
    } t_cmd;

endpackage

>>> sv/sms_ram.sv
`timescale 1ns / 1ps

module sms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sms_ctrl.sv
`timescale 1ns / 1ps

module sms_ctrl import sms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REMOVE = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    t_cmd       cmd;

    // sequencing: take word, drop oldest, insert and publish
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                cmd.remove = 1'b1;
                n_state    = ST_INSERT;
            end
            ST_INSERT: begin
                // wait until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.insert = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.insert) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> sv/sms_dp.sv
`timescale 1ns / 1ps

module sms_dp import sms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_flush,
    input  logic [LEN_BITS-1:0]    i_len_raw,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_window_full,
    output logic                   o_alert,
    output logic [DBL_BITS-1:0]    o_doubled_median,
    output logic [CNT_BITS-1:0]    o_alert_total
);

    // window state
    logic [SAMPLE_BITS-1:0] r_sorted [WINDOW_MAX];
    logic [FILL_BITS-1:0]   r_fill;
    logic [PTR_BITS-1:0]    r_ptr;
    logic [CNT_BITS-1:0]    r_count;

    // per-word working registers
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_full;
    logic [DBL_BITS-1:0]    r_doubled;

    // result register
    logic                   r_o_full;
    logic                   r_o_alert;
    logic [DBL_BITS-1:0]    r_o_doubled;
    logic [CNT_BITS-1:0]    r_o_total;

    logic [FILL_BITS-1:0]   len;
    logic                   full_now;
    logic [FILL_BITS-1:0]   half;
    logic [PTR_BITS-1:0]    idx_hi;
    logic [PTR_BITS-1:0]    idx_lo;
    logic [DBL_BITS-1:0]    median_sum;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [WINDOW_MAX-2:0]  lt_old;
    logic [SAMPLE_BITS-1:0] removed [WINDOW_MAX];
    logic [FILL_BITS-1:0]   ins_cnt;
    logic [WINDOW_MAX-1:0]  le_new;
    logic [SAMPLE_BITS-1:0] inserted [WINDOW_MAX];
    logic                   alert_now;
    logic [FILL_BITS-1:0]   ptr_inc;
    logic [PTR_BITS-1:0]    n_ptr;
    logic [CNT_BITS-1:0]    n_count;

    // effective window length, clamped to 1..max
    always_comb begin
        if (i_len_raw == '0) begin
            len = FILL_BITS'(1);
        end else if (int'(i_len_raw) > WINDOW_MAX) begin
            len = FILL_BITS'(WINDOW_MAX);
        end else begin
            len = FILL_BITS'(i_len_raw);
        end
    end

    assign full_now = (r_fill == len);

    // median taps: one middle element twice, or the two middle ones
    assign half       = len >> 1;
    assign idx_hi     = PTR_BITS'(half);
    assign idx_lo     = len[0] ? idx_hi : idx_hi - 1'b1;
    assign median_sum = {1'b0, r_sorted[idx_hi]} + {1'b0, r_sorted[idx_lo]};

    // arrival ring, oldest word read on capture
    sms_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert),
        .i_waddr (r_ptr),
        .i_wdata (r_sample),
        .i_re    (i_cmd.capture),
        .i_raddr (r_ptr),
        .o_rdata (oldest)
    );

    // removal: cells from the first copy of the oldest value shift down
    always_comb begin
        for (int k = 0; k < WINDOW_MAX - 1; k++) begin
            lt_old[k] = (k < int'(len)) && (r_sorted[k] < oldest);
        end
        for (int k = 0; k < WINDOW_MAX - 1; k++) begin
            removed[k] = lt_old[k] ? r_sorted[k] : r_sorted[k+1];
        end
        removed[WINDOW_MAX-1] = r_sorted[WINDOW_MAX-1];
    end

    // insertion after any equal values: cells above the slot shift up
    assign ins_cnt = r_full ? r_fill - 1'b1 : r_fill;

    always_comb begin
        for (int k = 0; k < WINDOW_MAX; k++) begin
            le_new[k] = (k < int'(ins_cnt)) && (r_sorted[k] <= r_sample);
        end
        inserted[0] = le_new[0] ? r_sorted[0] : r_sample;
        for (int k = 1; k < WINDOW_MAX; k++) begin
            if (le_new[k]) begin
                inserted[k] = r_sorted[k];
            end else if (le_new[k-1]) begin
                inserted[k] = r_sample;
            end else begin
                inserted[k] = r_sorted[k-1];
            end
        end
    end

    // threshold test and saturating count
    assign alert_now = r_full && ({1'b0, r_sample} >= r_doubled);

    always_comb begin
        n_count = r_count;
        if (alert_now && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    // ring pointer wraps at the window length
    assign ptr_inc = FILL_BITS'(r_ptr) + 1'b1;
    assign n_ptr   = (ptr_inc == len) ? '0 : PTR_BITS'(ptr_inc);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_ptr   <= '0;
            r_count <= '0;
        end else if (i_flush) begin
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.insert) begin
            r_ptr   <= n_ptr;
            r_count <= n_count;
            if (!r_full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // sorted cells, working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.remove) begin
            r_full    <= full_now;
            r_doubled <= full_now ? median_sum : '0;
            if (full_now) begin
                r_sorted <= removed;
            end
        end
        if (i_cmd.insert) begin
            r_sorted    <= inserted;
            r_o_full    <= r_full;
            r_o_alert   <= alert_now;
            r_o_doubled <= r_doubled;
            r_o_total   <= n_count;
        end
    end

    assign o_window_full    = r_o_full;
    assign o_alert          = r_o_alert;
    assign o_doubled_median = r_o_doubled;
    assign o_alert_total    = r_o_total;

endmodule

>>> sv/sliding_median_spike_alert.sv
`timescale 1ns / 1ps
// Sliding median spike detector. Samples arrive on the i_sample valid/ready
// channel; each accepted word yields exactly one result word on the o_result
// channel (window_full, alert, doubled_median, alert_total).
// The window length register (address 0) is written over the APB port; any
// write empties the window but keeps the alert count. Write it only while idle.
// Each word is worked in order: read of the oldest word from the ring RAM,
// removal from the sorted cells, then insertion; the next word is taken only
// once the last one has been inserted.
// The sorted copy is a row of shifting registers; the arrival order sits in a
// 64-entry RAM, so no clearing pass is needed after reset.
// A stalled receiver holds the result in its output register; the next sample
// is still taken and worked on, and the block then waits in its insert step
// until the pending result is taken.
// Reset (synchronous, active low) sets window length to 1, empties the window
// and clears the alert count.
`include "sliding_median_spike_alert_defines.svh"

module sliding_median_spike_alert import sms_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     i_sample_valid,
    output logic                     o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_result_valid,
    input  logic                     i_result_ready,
    output logic                     o_window_full,
    output logic                     o_alert,
    output logic [DBL_BITS-1:0]      o_doubled_median,
    output logic [CNT_BITS-1:0]      o_alert_total
);

    logic [LEN_BITS-1:0]     r_len;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_wr;
    logic                    len_hit;
    t_cmd                    cmd;

    // register decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign len_hit = (reg_idx == REG_WINDOW_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = len_hit ? APB_DATA_BITS'(r_len) : '0;

    // window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_BITS'(1);
        end else if (cfg_wr && len_hit) begin
            r_len <= pwdata[LEN_BITS-1:0];
        end
    end

    sms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample_valid),
        .o_in_ready  (o_sample_ready),
        .i_out_ready (i_result_ready),
        .o_out_valid (o_result_valid),
        .o_cmd       (cmd)
    );

    sms_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_flush          (cfg_wr && len_hit),
        .i_len_raw        (r_len),
        .i_sample         (i_sample),
        .o_window_full    (o_window_full),
        .o_alert          (o_alert),
        .o_doubled_median (o_doubled_median),
        .o_alert_total    (o_alert_total)
    );

    // checks
    `SMS_ASSERT_NEXT(a_one_word_in_flight, i_sample_valid && o_sample_ready, !o_sample_ready, "sample taken while another is in flight")
    `SMS_ASSERT_SAME(a_warmup_quiet, o_result_valid && !o_window_full, !o_alert && (o_doubled_median == '0), "warm-up result carries an alert or a median")
    `SMS_ASSERT_SAME(a_alert_counted, o_result_valid && o_alert, o_alert_total != '0, "alert raised with a zero alert count")
    `SMS_ASSERT_SAME(a_total_monotonic, o_result_valid && $past(o_result_valid), o_alert_total >= $past(o_alert_total), "alert count went down")

endmodule

>>> sim/sliding_median_spike_alert_tb.sv
`timescale 1ns / 1ps

module sliding_median_spike_alert_tb import sms_pkg::*; ();

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int SEGMENTS      = 15;
    localparam int FIXED_SEGS    = 12;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    // one result word as the block should emit it
    typedef struct {
        logic                full;
        logic                alert;
        logic [DBL_BITS-1:0] doubled;
        logic [CNT_BITS-1:0] total;
    } t_spike_result;

    // window of one: warm-up, zero median, largest median, exact threshold
    localparam t_sample SINGLE_RUN [6] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                                           16'd32767, 16'd65534};
    // even window with repeated values
    localparam t_sample EVEN_RUN [7] = '{16'd10, 16'd10, 16'd20, 16'd10,
                                         16'd40, 16'd19, 16'd10};
    // odd window, exact threshold on the first full word
    localparam t_sample ODD_RUN [4] = '{16'd7, 16'd7, 16'd7, 16'd14};
    // window length written as zero behaves as one
    localparam t_sample ZERO_LEN_RUN [3] = '{16'd300, 16'd600, 16'd599};
    // lengths per random segment: extremes, out of range, odd and even
    localparam logic [LEN_BITS-1:0] SEGMENT_LENGTHS [FIXED_SEGS] = '{
        7'd64, 7'd5, 7'd2, 7'd0, 7'd127, 7'd33,
        7'd64, 7'd1, 7'd16, 7'd65, 7'd64, 7'd9
    };

    // tracks the window, predicts each result word and checks the block's words
    class median_tracker;
        logic [LEN_BITS-1:0] length_reg;
        t_sample             arrivals [WINDOW_MAX];
        t_sample             ranked [$];
        int unsigned         oldest_slot;
        int unsigned         held;
        logic [CNT_BITS-1:0] alerts;
        t_spike_result       awaited [$];
        int unsigned         failures;

        function new();
            length_reg  = LEN_BITS'(1);
            oldest_slot = 0;
            held        = 0;
            alerts      = '0;
            failures    = 0;
        endfunction

        function int unsigned span();
            if (length_reg == 0) return 1;
            if (length_reg > WINDOW_MAX) return WINDOW_MAX;
            return int'(length_reg);
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // new value goes after any equal ones
        function void rank_insert(t_sample v);
            int pos;
            pos = 0;
            while (pos < ranked.size() && ranked[pos] <= v) pos++;
            ranked.insert(pos, v);
        endfunction

        // drop the first copy of the value
        function void rank_remove(t_sample v);
            int pos;
            pos = 0;
            while (pos < ranked.size() && ranked[pos] != v) pos++;
            if (pos < ranked.size()) ranked.delete(pos);
        endfunction

        // any write empties the window, alert count survives
        function void note_length(logic [LEN_BITS-1:0] v);
            length_reg  = v;
            held        = 0;
            oldest_slot = 0;
            ranked.delete();
        endfunction

        function void note_sample(t_sample s);
            int unsigned   len;
            t_spike_result r;
            len       = span();
            r.full    = 1'b0;
            r.alert   = 1'b0;
            r.doubled = '0;
            if (held < len) begin
                // warming up: store only
                arrivals[oldest_slot] = s;
                rank_insert(s);
                held++;
            end else begin
                r.full = 1'b1;
                if (len % 2 == 1)
                    r.doubled = {ranked[len / 2], 1'b0};
                else
                    r.doubled = DBL_BITS'(ranked[len / 2]) + DBL_BITS'(ranked[len / 2 - 1]);
                if (DBL_BITS'(s) >= r.doubled) begin
                    r.alert = 1'b1;
                    if (alerts != '1) alerts++;
                end
                // oldest word leaves, new one takes its slot
                rank_remove(arrivals[oldest_slot]);
                rank_insert(s);
                arrivals[oldest_slot] = s;
            end
            oldest_slot = (oldest_slot + 1) % len;
            r.total = alerts;
            awaited = {awaited, r};
        endfunction

        function void check_result(logic full, logic alert, logic [DBL_BITS-1:0] doubled,
                                   logic [CNT_BITS-1:0] total);
            t_spike_result want;
            if (awaited.size() == 0) begin
                $error("result word with nothing expected: doubled_median %0d", doubled);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (full !== want.full) begin
                $error("window_full: expected %0d, got %0d", want.full, full);
                failures++;
            end
            if (alert !== want.alert) begin
                $error("alert: expected %0d, got %0d", want.alert, alert);
                failures++;
            end
            if (doubled !== want.doubled) begin
                $error("doubled_median: expected %0d, got %0d", want.doubled, doubled);
                failures++;
            end
            if (total !== want.total) begin
                $error("alert_total: expected %0d, got %0d", want.total, total);
                failures++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_sample_valid;
    logic                     o_sample_ready;
    t_sample                  i_sample;
    logic                     o_result_valid;
    logic                     i_result_ready;
    logic                     o_window_full;
    logic                     o_alert;
    logic [DBL_BITS-1:0]      o_doubled_median;
    logic [CNT_BITS-1:0]      o_alert_total;

    int unsigned   send_idle_pct;
    int unsigned   take_idle_pct;
    median_tracker board = new();

    sliding_median_spike_alert dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_sample_valid   (i_sample_valid),
        .o_sample_ready   (o_sample_ready),
        .i_sample         (i_sample),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .o_window_full    (o_window_full),
        .o_alert          (o_alert),
        .o_doubled_median (o_doubled_median),
        .o_alert_total    (o_alert_total)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_result_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready)
            board.check_result(o_window_full, o_alert, o_doubled_median, o_alert_total);
    end

    // offer one sample word, starting and ending on a falling edge
    task automatic send_sample(input t_sample v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
        board.note_sample(v);
        @(negedge i_clk);
    endtask

    // register write once the block has drained
    task automatic write_window_length(input logic [LEN_BITS-1:0] len_val);
        i_sample_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata  <= APB_DATA_BITS'(len_val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.note_length(len_val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // baseline around a level, some spikes, some full-range noise
    function automatic t_sample next_sample(int unsigned level, int unsigned spread);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(99);
        if (r < 10)
            v = $urandom_range(65535);
        else if (r < 25)
            v = 2 * level + $urandom_range(2 * level + 3);
        else
            v = level + $urandom_range(spread);
        if (v > 65535) v = 65535;
        return t_sample'(v);
    endfunction

    // stimulus
    initial begin
        logic [LEN_BITS-1:0] len_val;
        int unsigned         eff_len;
        int unsigned         level;
        int unsigned         spread;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_sample_valid = 1'b0;
        i_sample       = '0;
        send_idle_pct  = 24;
        take_idle_pct  = 80;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset length of one
        foreach (SINGLE_RUN[k]) send_sample(SINGLE_RUN[k]);
        write_window_length(7'd4);
        foreach (EVEN_RUN[k]) send_sample(EVEN_RUN[k]);
        write_window_length(7'd3);
        foreach (ODD_RUN[k]) send_sample(ODD_RUN[k]);
        // same length again still flushes
        write_window_length(7'd3);
        send_sample(16'd5);
        send_sample(16'd5);
        write_window_length(7'd0);
        foreach (ZERO_LEN_RUN[k]) send_sample(ZERO_LEN_RUN[k]);

        // random segments, one length each
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 5) begin
                send_idle_pct = 80;
                take_idle_pct = 24;
            end
            if (seg == 10) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            len_val = (seg < FIXED_SEGS) ? SEGMENT_LENGTHS[seg]
                                         : LEN_BITS'($urandom_range(127));
            write_window_length(len_val);
            eff_len = (len_val == 0) ? 1 : (len_val > WINDOW_MAX) ? WINDOW_MAX : len_val;
            case ($urandom_range(3))
                0: begin
                    // tiny values, many duplicates and zero medians
                    level  = $urandom_range(6);
                    spread = 2;
                end
                1: begin
                    level  = $urandom_range(2000, 50);
                    spread = level / 2 + 3;
                end
                2: begin
                    level  = $urandom_range(30000, 5000);
                    spread = level / 2 + 3;
                end
                default: begin
                    level  = $urandom_range(65535);
                    spread = level / 2 + 3;
                end
            endcase
            for (int n = 0; n < 40 + 2 * eff_len; n++)
                send_sample(next_sample(level, spread));
        end

        // drain, then let any stray word show up
        i_sample_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (board.failures == 0)
            $display("sliding_median_spike_alert verification clean");
        else
            $display("sliding_median_spike_alert verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("sliding_median_spike_alert verification failed");
        $finish;
    end

endmodule
